/* rtl/svalloc_pkg.sv */
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared types, constants and helpers for the voice allocator: request mode
// codes, the scan word that ripples through the voice cells and the command
// broadcast to them.
// ----------------------------------------------------------------------------
package svalloc_pkg;

   // default voice count and the widest index the scan word can carry
   localparam int VOICES_DEF = 16;
   localparam int IDX_W      = 6;
   localparam int NOTE_W     = 7;
   localparam int FREQ_W     = 32;
   localparam int FIN_W      = 4;
   localparam int VIDX_W     = 4;
   localparam int MASK_W     = 16;
   localparam int AGE_W      = 31;

   localparam logic [AGE_W-1:0]  AGE_LIMIT = {AGE_W{1'b1}};
   localparam logic [NOTE_W:0]   NOTE_CEIL = 8'd128;

   // request mode codes
   localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
   localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
   localparam logic [1:0] MODE_FINISHED = 2'd2;
   localparam logic [1:0] MODE_STOP_ALL = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN1,
      ST_SCAN2,
      ST_APPLY
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_RELEASE_NOTE,
      CMD_RELEASE_ALL,
      CMD_FREE
   } cmd_op_type;

   // command broadcast to every cell
   typedef struct packed {
      cmd_op_type        op;
      logic [IDX_W-1:0]  idx;
      logic [NOTE_W-1:0] note;
      logic [AGE_W-1:0]  age;
   } cmd_type;

   // scan word; pass 0 finds lowest/highest note and the free voice,
   // pass 1 finds the oldest releasing and oldest overall voice
   typedef struct packed {
      logic              valid;
      logic              pass;
      logic [NOTE_W:0]   lo_note;
      logic [IDX_W-1:0]  lo_idx;
      logic [NOTE_W-1:0] hi_note;
      logic [IDX_W-1:0]  hi_idx;
      logic              have_free;
      logic [IDX_W-1:0]  free_idx;
      logic              have_rel;
      logic [IDX_W-1:0]  rel_idx;
      logic [AGE_W-1:0]  rel_age;
      logic [IDX_W-1:0]  old_idx;
      logic [AGE_W-1:0]  old_age;
   } scan_type;

   function automatic scan_type scan_init();
      scan_type s;
      s.valid     = 1'b1;
      s.pass      = 1'b0;
      s.lo_note   = NOTE_CEIL;
      s.lo_idx    = '0;
      s.hi_note   = '0;
      s.hi_idx    = '0;
      s.have_free = 1'b0;
      s.free_idx  = '0;
      s.have_rel  = 1'b0;
      s.rel_idx   = '0;
      s.rel_age   = AGE_LIMIT;
      s.old_idx   = '0;
      s.old_age   = AGE_LIMIT;
      return s;
   endfunction

endpackage

/* rtl/svalloc_cell.sv */
// ----------------------------------------------------------------------------
// svalloc_cell
// One voice slot: holds note, age, playing and releasing state, updates the
// scan word passing through it and applies broadcast commands.
// ----------------------------------------------------------------------------
module svalloc_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  svalloc_pkg::scan_type scan_in,
   output svalloc_pkg::scan_type scan_out,
   input  svalloc_pkg::cmd_type  cmd,
   output logic                  rel_hit
);

   localparam logic [svalloc_pkg::IDX_W-1:0] MY_IDX = svalloc_pkg::IDX_W'(INDEX);

   logic [svalloc_pkg::NOTE_W-1:0] note_ff;
   logic [svalloc_pkg::AGE_W-1:0]  age_ff;
   logic                           playing_ff;
   logic                           releasing_ff;
   svalloc_pkg::scan_type          scan_ff, scan_next_in;

   always_comb begin
      scan_next_in = scan_in;
      if (scan_in.valid) begin
         if (!scan_in.pass) begin
            if (playing_ff && ({1'b0, note_ff} < scan_in.lo_note)) begin
               scan_next_in.lo_note = {1'b0, note_ff};
               scan_next_in.lo_idx  = MY_IDX;
            end
            if (playing_ff && (note_ff > scan_in.hi_note)) begin
               scan_next_in.hi_note = note_ff;
               scan_next_in.hi_idx  = MY_IDX;
            end
            if (!playing_ff) begin
               scan_next_in.have_free = 1'b1;
               scan_next_in.free_idx  = MY_IDX;
            end
         end else if ((MY_IDX != scan_in.lo_idx) && (MY_IDX != scan_in.hi_idx)) begin
            if (releasing_ff && (age_ff < scan_in.rel_age)) begin
               scan_next_in.have_rel = 1'b1;
               scan_next_in.rel_idx  = MY_IDX;
               scan_next_in.rel_age  = age_ff;
            end
            if (age_ff < scan_in.old_age) begin
               scan_next_in.old_idx = MY_IDX;
               scan_next_in.old_age = age_ff;
            end
         end
      end
   end

   always_comb begin
      rel_hit = 1'b0;
      if (playing_ff && !releasing_ff) begin
         rel_hit = (cmd.op == svalloc_pkg::CMD_RELEASE_ALL) ||
                   ((cmd.op == svalloc_pkg::CMD_RELEASE_NOTE) && (cmd.note == note_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         note_ff      <= '0;
         age_ff       <= '0;
         playing_ff   <= 1'b0;
         releasing_ff <= 1'b0;
      end else begin
         scan_ff <= scan_next_in;
         case (cmd.op)
            svalloc_pkg::CMD_START: begin
               if (cmd.idx == MY_IDX) begin
                  note_ff      <= cmd.note;
                  age_ff       <= cmd.age;
                  playing_ff   <= 1'b1;
                  releasing_ff <= 1'b0;
               end
            end
            svalloc_pkg::CMD_FREE: begin
               if (cmd.idx == MY_IDX) begin
                  playing_ff   <= 1'b0;
                  releasing_ff <= 1'b0;
               end
            end
            svalloc_pkg::CMD_RELEASE_NOTE, svalloc_pkg::CMD_RELEASE_ALL: begin
               if (rel_hit) begin
                  releasing_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign scan_out = scan_ff;

endmodule

/* rtl/svalloc_ctrl.sv */
// ----------------------------------------------------------------------------
// svalloc_ctrl
// Sequencer: takes requests, launches the two scans down the cell chain,
// keeps the age counter, issues commands and holds the response register.
// ----------------------------------------------------------------------------
module svalloc_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [svalloc_pkg::NOTE_W-1:0]      req_note,
   input  logic [svalloc_pkg::FREQ_W-1:0]      req_frequency,
   input  logic [svalloc_pkg::FIN_W-1:0]       req_finished_voice,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_start_valid,
   output logic [svalloc_pkg::VIDX_W-1:0]      rsp_voice_index,
   output logic                                rsp_stolen,
   output logic [svalloc_pkg::NOTE_W-1:0]      rsp_start_note,
   output logic [svalloc_pkg::FREQ_W-1:0]      rsp_start_frequency,
   output logic [svalloc_pkg::MASK_W-1:0]      rsp_release_mask,
   output svalloc_pkg::scan_type               chain_in,
   input  svalloc_pkg::scan_type               chain_out,
   output svalloc_pkg::cmd_type                cmd,
   input  logic [svalloc_pkg::MASK_W-1:0]      rel_hits
);

   svalloc_pkg::state_type state_ff, state_in;

   logic [1:0]                          mode_ff, mode_in;
   logic [svalloc_pkg::NOTE_W-1:0]      note_ff, note_in;
   logic [svalloc_pkg::FREQ_W-1:0]      freq_ff, freq_in;
   logic [svalloc_pkg::FIN_W-1:0]       fin_ff, fin_in;
   logic [svalloc_pkg::AGE_W-1:0]       age_cnt_ff, age_cnt_in;
   svalloc_pkg::scan_type               scan_ff, scan_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_start_ff, rsp_start_in;
   logic [svalloc_pkg::VIDX_W-1:0]      rsp_vidx_ff, rsp_vidx_in;
   logic                                rsp_stolen_ff, rsp_stolen_in;
   logic [svalloc_pkg::NOTE_W-1:0]      rsp_note_ff, rsp_note_in;
   logic [svalloc_pkg::FREQ_W-1:0]      rsp_freq_ff, rsp_freq_in;
   logic [svalloc_pkg::MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;

   logic                                accept;
   logic                                slot_free;
   logic [svalloc_pkg::IDX_W-1:0]       pick;
   logic [svalloc_pkg::AGE_W-1:0]       age_next;

   assign req_ready = (state_ff == svalloc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign pick = scan_ff.have_free ? scan_ff.free_idx :
                 (scan_ff.have_rel ? scan_ff.rel_idx : scan_ff.old_idx);
   assign age_next = (age_cnt_ff < svalloc_pkg::AGE_LIMIT) ?
                     (age_cnt_ff + svalloc_pkg::AGE_W'(1)) : age_cnt_ff;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      note_in    = note_ff;
      freq_in    = freq_ff;
      fin_in     = fin_ff;
      age_cnt_in = age_cnt_ff;
      scan_in    = scan_ff;

      chain_in       = svalloc_pkg::scan_init();
      chain_in.valid = 1'b0;

      cmd.op   = svalloc_pkg::CMD_NONE;
      cmd.idx  = pick;
      cmd.note = note_ff;
      cmd.age  = age_next;

      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_vidx_in   = rsp_vidx_ff;
      rsp_stolen_in = rsp_stolen_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_mask_in   = rsp_mask_ff;

      case (state_ff)
         svalloc_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               note_in = req_note;
               freq_in = req_frequency;
               fin_in  = req_finished_voice;
               if (req_mode == svalloc_pkg::MODE_NOTE_ON) begin
                  chain_in = svalloc_pkg::scan_init();
                  state_in = svalloc_pkg::ST_SCAN1;
               end else begin
                  state_in = svalloc_pkg::ST_APPLY;
               end
            end
         end
         svalloc_pkg::ST_SCAN1: begin
            // first pass done: send it back in with lowest/highest fixed
            if (chain_out.valid) begin
               chain_in          = chain_out;
               chain_in.pass     = 1'b1;
               chain_in.have_rel = 1'b0;
               chain_in.rel_idx  = '0;
               chain_in.rel_age  = svalloc_pkg::AGE_LIMIT;
               chain_in.old_idx  = '0;
               chain_in.old_age  = svalloc_pkg::AGE_LIMIT;
               state_in          = svalloc_pkg::ST_SCAN2;
            end
         end
         svalloc_pkg::ST_SCAN2: begin
            if (chain_out.valid) begin
               scan_in  = chain_out;
               state_in = svalloc_pkg::ST_APPLY;
            end
         end
         svalloc_pkg::ST_APPLY: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = 1'b0;
               rsp_vidx_in   = '0;
               rsp_stolen_in = 1'b0;
               rsp_note_in   = '0;
               rsp_freq_in   = '0;
               rsp_mask_in   = '0;
               state_in      = svalloc_pkg::ST_IDLE;
               case (mode_ff)
                  svalloc_pkg::MODE_NOTE_ON: begin
                     cmd.op        = svalloc_pkg::CMD_START;
                     age_cnt_in    = age_next;
                     rsp_start_in  = 1'b1;
                     rsp_vidx_in   = pick[svalloc_pkg::VIDX_W-1:0];
                     rsp_stolen_in = !scan_ff.have_free;
                     rsp_note_in   = note_ff;
                     rsp_freq_in   = freq_ff;
                  end
                  svalloc_pkg::MODE_NOTE_OFF: begin
                     cmd.op      = svalloc_pkg::CMD_RELEASE_NOTE;
                     rsp_mask_in = rel_hits;
                  end
                  svalloc_pkg::MODE_FINISHED: begin
                     cmd.op  = svalloc_pkg::CMD_FREE;
                     cmd.idx = svalloc_pkg::IDX_W'(fin_ff);
                  end
                  default: begin
                     cmd.op      = svalloc_pkg::CMD_RELEASE_ALL;
                     rsp_mask_in = rel_hits;
                  end
               endcase
            end
         end
         default: begin
            state_in = svalloc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svalloc_pkg::ST_IDLE;
         age_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         age_cnt_ff   <= age_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      note_ff       <= note_in;
      freq_ff       <= freq_in;
      fin_ff        <= fin_in;
      scan_ff       <= scan_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_vidx_ff   <= rsp_vidx_in;
      rsp_stolen_ff <= rsp_stolen_in;
      rsp_note_ff   <= rsp_note_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_start_valid     = rsp_start_ff;
   assign rsp_voice_index     = rsp_vidx_ff;
   assign rsp_stolen          = rsp_stolen_ff;
   assign rsp_start_note      = rsp_note_ff;
   assign rsp_start_frequency = rsp_freq_ff;
   assign rsp_release_mask    = rsp_mask_ff;

endmodule

/* rtl/synth_voice_allocator.sv */
// ----------------------------------------------------------------------------
// synth_voice_allocator
// Voice table allocator for a polyphonic synthesizer, built as a chain of
// voice cells with a scan word rippling one cell per clock.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  mode, note, frequency,
//                                              finished_voice
//   rsp_     out        rsp_valid / rsp_ready  start_valid, voice_index,
//                                              stolen, start_note,
//                                              start_frequency, release_mask
//
// note on runs two scan waves, each one cell per clock through the chain,
// then applies the result; other requests go straight to the apply step.
// one request is in flight at a time; req_ready is high only when idle.
// the response register holds a result until taken; a stalled rsp_ready
// holds the sequencer in its final step.
// synchronous active-high reset clears all voices and the age counter.
// ----------------------------------------------------------------------------
module synth_voice_allocator #(
   parameter int VOICES = svalloc_pkg::VOICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [svalloc_pkg::NOTE_W-1:0]      req_note,
   input  logic [svalloc_pkg::FREQ_W-1:0]      req_frequency,
   input  logic [svalloc_pkg::FIN_W-1:0]       req_finished_voice,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_start_valid,
   output logic [svalloc_pkg::VIDX_W-1:0]      rsp_voice_index,
   output logic                                rsp_stolen,
   output logic [svalloc_pkg::NOTE_W-1:0]      rsp_start_note,
   output logic [svalloc_pkg::FREQ_W-1:0]      rsp_start_frequency,
   output logic [svalloc_pkg::MASK_W-1:0]      rsp_release_mask
);

   svalloc_pkg::scan_type             chain [VOICES+1];
   svalloc_pkg::cmd_type              cmd;
   logic [VOICES-1:0]                 hits;
   logic [svalloc_pkg::MASK_W-1:0]    hits16;

   svalloc_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_note            (req_note),
      .req_frequency       (req_frequency),
      .req_finished_voice  (req_finished_voice),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_start_valid     (rsp_start_valid),
      .rsp_voice_index     (rsp_voice_index),
      .rsp_stolen          (rsp_stolen),
      .rsp_start_note      (rsp_start_note),
      .rsp_start_frequency (rsp_start_frequency),
      .rsp_release_mask    (rsp_release_mask),
      .chain_in            (chain[0]),
      .chain_out           (chain[VOICES]),
      .cmd                 (cmd),
      .rel_hits            (hits16)
   );

   for (genvar v = 0; v < VOICES; v++) begin : g_cell
      svalloc_cell #(
         .INDEX (v)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (chain[v]),
         .scan_out (chain[v+1]),
         .cmd      (cmd),
         .rel_hit  (hits[v])
      );
   end

   // voices beyond the mask width are not reported
   for (genvar b = 0; b < svalloc_pkg::MASK_W; b++) begin : g_mask
      if (b < VOICES) begin : g_used
         assign hits16[b] = hits[b];
      end else begin : g_unused
         assign hits16[b] = 1'b0;
      end
   end

endmodule
